[rtl/bmp_pkg.sv]
// Shared types and constants for the MSB-first bit packer.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package bmp_pkg;

	localparam int VALUE_W = 25;
	localparam int LEN_W   = 5;
	localparam int ACC_W   = 32;
	localparam int CNT_W   = 6;
	localparam int BYTE_W  = 8;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_FLUSH  = 1'b1;

	typedef struct packed {
		logic               flush;
		logic [ACC_W-1:0]   code;
		logic [LEN_W-1:0]   len;
	} cmd_t;

endpackage

`default_nettype wire

[rtl/bmp_code_if.sv]
// Input channel of the bit packer: one append or flush request per transfer.
// Depends on bmp_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bmp_code_if;
	import bmp_pkg::*;

	logic               valid;
	logic               ready;
	logic               operation;
	logic [VALUE_W-1:0] code_value;
	logic [LEN_W-1:0]   code_length;

	modport source (output valid, output operation, output code_value,
		output code_length, input ready);
	modport sink (input valid, input operation, input code_value,
		input code_length, output ready);
endinterface

`default_nettype wire

[rtl/bmp_byte_if.sv]
// Output channel of the bit packer: one packed byte per transfer.
// Depends on bmp_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bmp_byte_if;
	import bmp_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              last_byte;

	modport source (output valid, output out_byte, output last_byte, input ready);
	modport sink (input valid, input out_byte, input last_byte, output ready);
endinterface

`default_nettype wire

[rtl/msb_first_bit_packer.sv]
// Top level of the MSB-first variable-length bit packer.
// Depends on bmp_pkg, bmp_code_if, bmp_byte_if, bmp_front, bmp_queue, bmp_back.
`timescale 1ns / 1ps
`default_nettype none

// Packs codes of 1 to MAX_CODE_BITS bits, earliest bit first, into bytes.
// An append transfer on code_ch adds code_length bits (longer lengths are
// clamped to MAX_CODE_BITS, value bits above the length are ignored) and
// produces every byte it completes, zero to four. A flush transfer sends the
// pending partial byte, zero-padded at the low end, if any bits are pending,
// and clears the packer. The final byte caused by a request has last_byte set;
// a request that completes no byte produces nothing. Timing: the front end
// takes a request every cycle while its two-entry queue has room; the back
// end loads a request into the accumulator and then emits its bytes one per
// cycle while byte_ch does not stall, and it takes the next request only
// once it has formed every byte of the last one. Zero-length appends are
// dropped at the front end and never reach the back end. The output register
// lets the back end load a request while a byte waits on byte_ch.

module msb_first_bit_packer #(
	parameter int MAX_CODE_BITS = 25
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	bmp_code_if.sink   code_ch,
	bmp_byte_if.source byte_ch
);
	import bmp_pkg::*;

	cmd_t front_cmd;
	cmd_t queue_cmd;
	logic push;
	logic pop;
	logic full;
	logic empty;

	// Front: classify and left-align each request
	bmp_front #(
		.MAX_CODE_BITS(MAX_CODE_BITS)
	) u_front (
		.code_ch (code_ch),
		.full    (full),
		.push    (push),
		.cmd     (front_cmd)
	);

	// Decouples request intake from byte draining
	bmp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (front_cmd),
		.pop    (pop),
		.rd_cmd (queue_cmd),
		.full   (full),
		.empty  (empty)
	);

	// Back: accumulator update and byte output
	bmp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (queue_cmd),
		.empty   (empty),
		.pop     (pop),
		.byte_ch (byte_ch)
	);

endmodule

`default_nettype wire

[rtl/bmp_front.sv]
// Front end: accepts requests, saturates the length and left-aligns the code.
// Depends on bmp_pkg and bmp_code_if.
`timescale 1ns / 1ps
`default_nettype none

module bmp_front #(
	parameter int MAX_CODE_BITS = 25
) (
	bmp_code_if.sink          code_ch,
	input  wire logic         full,
	output logic              push,
	output bmp_pkg::cmd_t     cmd
);
	import bmp_pkg::*;

	logic [LEN_W-1:0] len_sat;
	logic [CNT_W-1:0] shamt;

	always_comb begin
		if (code_ch.code_length > LEN_W'(MAX_CODE_BITS)) begin
			len_sat = LEN_W'(MAX_CODE_BITS);
		end else begin
			len_sat = code_ch.code_length;
		end
	end

	// Shifting into the top of a 32-bit word drops the value bits above the length.
	assign shamt     = CNT_W'(ACC_W) - CNT_W'(len_sat);
	assign cmd.flush = (code_ch.operation == OP_FLUSH);
	assign cmd.len   = len_sat;
	assign cmd.code  = {{(ACC_W-VALUE_W){1'b0}}, code_ch.code_value} << shamt;

	assign code_ch.ready = !full;

	// Zero-length appends are consumed here and never reach the back end.
	assign push = code_ch.valid && !full
		&& ((code_ch.operation == OP_FLUSH) || (code_ch.code_length != '0));

endmodule

`default_nettype wire

[rtl/bmp_queue.sv]
// Short command queue between the front and back ends.
// Depends on bmp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bmp_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire bmp_pkg::cmd_t wr_cmd,
	input  wire logic          pop,
	output bmp_pkg::cmd_t      rd_cmd,
	output logic               full,
	output logic               empty
);
	import bmp_pkg::*;

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full   = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty  = (count_q == '0);
	assign rd_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/bmp_back.sv]
// Back end: owns the bit accumulator and drains complete bytes one per cycle while byte_ch does not stall.
// Depends on bmp_pkg and bmp_byte_if.
`timescale 1ns / 1ps
`default_nettype none

module bmp_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire bmp_pkg::cmd_t cmd,
	input  wire logic          empty,
	output logic               pop,
	bmp_byte_if.source         byte_ch
);
	import bmp_pkg::*;

	logic [ACC_W-1:0]  acc_q;
	logic [CNT_W-1:0]  cnt_q;    // bits held; below 8 whenever idle
	logic              busy_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              last_q;

	logic [ACC_W-1:0]  acc_next;
	logic [CNT_W-1:0]  cnt_next;
	logic              emit;

	assign pop  = !busy_q && !empty;
	assign emit = busy_q && (!out_valid_q || byte_ch.ready);

	// Flush reuses the drain path: one byte if anything is pending, else nothing.
	always_comb begin
		if (cmd.flush) begin
			acc_next = acc_q;
			cnt_next = (cnt_q != '0) ? CNT_W'(BYTE_W) : '0;
		end else begin
			acc_next = acc_q | (cmd.code >> cnt_q[2:0]);
			cnt_next = cnt_q + CNT_W'(cmd.len);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			cnt_q       <= '0;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				acc_q  <= acc_next;
				cnt_q  <= cnt_next;
				busy_q <= (cnt_next >= CNT_W'(BYTE_W));
			end else if (emit) begin
				acc_q  <= acc_q << BYTE_W;
				cnt_q  <= cnt_q - CNT_W'(BYTE_W);
				busy_q <= (cnt_q >= CNT_W'(2 * BYTE_W));
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (byte_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= acc_q[ACC_W-1 -: BYTE_W];
			last_q     <= (cnt_q < CNT_W'(2 * BYTE_W));
		end
	end

	assign byte_ch.valid     = out_valid_q;
	assign byte_ch.out_byte  = out_byte_q;
	assign byte_ch.last_byte = last_q;

endmodule

`default_nettype wire

[rtl/bmp_checker.sv]
// Port-level checks for the bit packer, bound onto the top level.
// Depends on bmp_pkg and msb_first_bit_packer.
`timescale 1ns / 1ps
`default_nettype none

module bmp_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      out_valid,
	input wire logic                      out_ready,
	input wire logic [bmp_pkg::BYTE_W-1:0] out_byte,
	input wire logic                      last_byte
);
	import bmp_pkg::*;

	logic [2:0] run_q;  // non-last bytes since the last marked byte

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
		end else if (out_valid && out_ready) begin
			run_q <= last_byte ? '0 : run_q + 1'b1;
		end
	end

	// A stalled byte holds its value
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last_byte))
		else $error("byte changed while stalled");

	// No request yields more than four bytes
	a_run_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_byte |-> run_q < 3'd3)
		else $error("more than four bytes for one request");

	// Bytes of one request follow without a gap
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_byte |=> out_valid)
		else $error("gap inside a request's bytes");

endmodule

bind msb_first_bit_packer bmp_checker u_bmp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (byte_ch.valid),
	.out_ready (byte_ch.ready),
	.out_byte  (byte_ch.out_byte),
	.last_byte (byte_ch.last_byte)
);

`default_nettype wire
